[rtl/bcbm_pkg.sv]
`default_nettype none

package bcbm_pkg;

    localparam int SONG_SHIFT      = 6;
    localparam int SUBSEQ_PER_SONG = 1 << SONG_SHIFT;

    localparam int CMD_W      = 3;
    localparam int ENTRY_W    = 32;
    localparam int COARSE_W   = 7;
    localparam int FINE_W     = 13;
    localparam int SONG_W     = 33;
    localparam int CFG_DATA_W = 13;

    localparam logic [COARSE_W-1:0] SCREENING_RESET = COARSE_W'(96);
    localparam logic [FINE_W-1:0]   SCRUTINY_RESET  = FINE_W'(4096);
    localparam logic [SONG_W-1:0]   NO_SONG         = '1;

    typedef enum logic [CMD_W-1:0] {
        CMD_RUN_START    = 3'd0,
        CMD_BUCKET_OPEN  = 3'd1,
        CMD_ENTRY        = 3'd2,
        CMD_FINE         = 3'd3,
        CMD_BUCKET_CLOSE = 3'd4
    } cmd_t;

    typedef enum logic {
        CFG_SCREENING_LIMIT = 1'b0,
        CFG_SCRUTINY_LIMIT  = 1'b1
    } cfg_index_t;

    typedef enum logic {
        KIND_LOCATION  = 1'b0,
        KIND_BEST_SONG = 1'b1
    } result_kind_t;

    typedef struct packed {
        logic [CMD_W-1:0]    cmd;
        logic [ENTRY_W-1:0]  table_entry;
        logic [COARSE_W-1:0] coarse_distance;
        logic [FINE_W-1:0]   fine_distance;
    } in_item_t;

    typedef struct packed {
        logic                     result_kind;
        logic [ENTRY_W-1:0]       location;
        logic signed [SONG_W-1:0] best_song;
    } out_item_t;

endpackage

`default_nettype wire

[rtl/bcbm_in_stage.sv]
`default_nettype none

module bcbm_in_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire bcbm_pkg::in_item_t in_data,
    output logic                   s1_valid,
    output bcbm_pkg::in_item_t     s1_data,
    input  wire logic              s1_take
);
    import bcbm_pkg::*;

    logic     valid_reg;
    logic     valid_next;
    in_item_t data_reg;

    assign in_ready   = !valid_reg || s1_take;
    assign valid_next = (in_valid && in_ready) ? 1'b1 : (s1_take ? 1'b0 : valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            data_reg <= in_data;
        end
    end

    assign s1_valid = valid_reg;
    assign s1_data  = data_reg;

endmodule

`default_nettype wire

[rtl/bcbm_core.sv]
`default_nettype none

module bcbm_core (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s1_valid,
    input  wire bcbm_pkg::in_item_t s1_data,
    output logic                    s1_take,
    input  wire logic               cfg_valid,
    output logic                    cfg_ready,
    input  wire logic               cfg_index,
    input  wire logic [bcbm_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output bcbm_pkg::out_item_t     out_data
);
    import bcbm_pkg::*;

    logic [COARSE_W-1:0] screening_limit_reg;
    logic [FINE_W-1:0]   scrutiny_limit_reg;
    logic [FINE_W-1:0]   least_distance_reg;
    logic [FINE_W-1:0]   least_distance_next;
    logic [SONG_W-1:0]   chosen_song_reg;
    logic [SONG_W-1:0]   chosen_song_next;
    logic [ENTRY_W-1:0]  candidate_song_reg;
    logic [ENTRY_W-1:0]  candidate_song_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    out_item_t           out_data_reg;
    out_item_t           out_data_next;
    logic                has_result;
    logic [ENTRY_W-1:0]  entry_song;

    assign cfg_ready = 1'b1;
    assign s1_take   = s1_valid && (!out_valid_reg || out_ready);
    assign entry_song = ENTRY_W'(s1_data.table_entry >> SONG_SHIFT);

    always_comb
    begin
        least_distance_next = least_distance_reg;
        chosen_song_next    = chosen_song_reg;
        candidate_song_next = candidate_song_reg;
        has_result          = 1'b0;
        out_data_next       = '0;
        case (s1_data.cmd)
            CMD_RUN_START:
            begin
                least_distance_next = scrutiny_limit_reg;
                chosen_song_next    = NO_SONG;
            end
            CMD_BUCKET_OPEN:
            begin
                chosen_song_next = NO_SONG;
            end
            CMD_ENTRY:
            begin
                if (s1_data.coarse_distance <= screening_limit_reg)
                begin
                    candidate_song_next    = entry_song;
                    has_result             = 1'b1;
                    out_data_next.result_kind = KIND_LOCATION;
                    out_data_next.location =
                        {s1_data.table_entry[ENTRY_W-1:SONG_SHIFT], {SONG_SHIFT{1'b0}}};
                end
            end
            CMD_FINE:
            begin
                if (s1_data.fine_distance <= least_distance_reg)
                begin
                    least_distance_next = s1_data.fine_distance;
                    chosen_song_next    = {1'b0, candidate_song_reg};
                end
            end
            CMD_BUCKET_CLOSE:
            begin
                has_result                = 1'b1;
                out_data_next.result_kind = KIND_BEST_SONG;
                out_data_next.best_song   = chosen_song_reg;
            end
            default:
            begin
                has_result = 1'b0;
            end
        endcase
    end

    assign out_valid_next = s1_take ? has_result : (out_ready ? 1'b0 : out_valid_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screening_limit_reg <= SCREENING_RESET;
            scrutiny_limit_reg  <= SCRUTINY_RESET;
            least_distance_reg  <= SCRUTINY_RESET;
            chosen_song_reg     <= NO_SONG;
            candidate_song_reg  <= '0;
            out_valid_reg       <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (s1_take)
            begin
                least_distance_reg <= least_distance_next;
                chosen_song_reg    <= chosen_song_next;
                candidate_song_reg <= candidate_song_next;
            end
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_SCREENING_LIMIT: screening_limit_reg <= cfg_data[COARSE_W-1:0];
                    CFG_SCRUTINY_LIMIT:  scrutiny_limit_reg  <= cfg_data[FINE_W-1:0];
                    default:             scrutiny_limit_reg  <= scrutiny_limit_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_take && has_result)
        begin
            out_data_reg <= out_data_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    a_close_gives_best: assert property (@(posedge clk) disable iff (!rst_n)
        s1_take && s1_data.cmd == CMD_BUCKET_CLOSE
        |=> out_valid_reg && out_data_reg.result_kind == KIND_BEST_SONG)
        else $error("Bucket close did not produce a best-song result.");

    a_entry_location_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        s1_take && s1_data.cmd == CMD_ENTRY
            && s1_data.coarse_distance <= screening_limit_reg
        |=> out_valid_reg && out_data_reg.result_kind == KIND_LOCATION
            && out_data_reg.location[SONG_SHIFT-1:0] == '0)
        else $error("Screened entry did not produce an aligned song location.");

    a_fine_updates_minimum: assert property (@(posedge clk) disable iff (!rst_n)
        s1_take && s1_data.cmd == CMD_FINE && s1_data.fine_distance <= least_distance_reg
        |=> least_distance_reg == $past(s1_data.fine_distance)
            && chosen_song_reg[SONG_W-1] == 1'b0)
        else $error("Fine distance did not update the running minimum.");

    a_run_start_clears: assert property (@(posedge clk) disable iff (!rst_n)
        s1_take && s1_data.cmd == CMD_RUN_START
        |=> chosen_song_reg == NO_SONG && least_distance_reg == $past(scrutiny_limit_reg))
        else $error("Run start did not reload the running minimum.");

endmodule

`default_nettype wire

[rtl/bucket_candidate_best_match_unit.sv]
// Pipeline: an accepted input transaction is held in the input register and its result in the
// result register; a result that waits to be taken stalls the input register.
// Throughput: one input transaction per cycle while no result waits untaken; the input
// register and the result register let the next item in while a result waits to be taken.
// Reset: asynchronous, active low; limits return to 96 and 4096, the running
// minimum to 4096, the best song to -1 and the candidate song to 0.
`default_nettype none

module bucket_candidate_best_match_unit (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    output logic                     in_ready,
    input  wire bcbm_pkg::in_item_t  in_data,
    output logic                     out_valid,
    input  wire logic                out_ready,
    output bcbm_pkg::out_item_t      out_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic                cfg_index,
    input  wire logic [bcbm_pkg::CFG_DATA_W-1:0] cfg_data
);
    import bcbm_pkg::*;

    logic     s1_valid;
    in_item_t s1_data;
    logic     s1_take;

    bcbm_in_stage u_in_stage (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .s1_valid (s1_valid),
        .s1_data  (s1_data),
        .s1_take  (s1_take)
    );

    bcbm_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .s1_valid  (s1_valid),
        .s1_data   (s1_data),
        .s1_take   (s1_take),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

`default_nettype wire
